/* rtl/multi_slot_tick_timer_assert.svh */
// Assertion macros shared by the timer's checker.
`ifndef MULTI_SLOT_TICK_TIMER_ASSERT_SVH
`define MULTI_SLOT_TICK_TIMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MSTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MSTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mstt_pkg.sv */
// Constants, types and helpers for the multi-slot tick timer.
package mstt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int PERIOD_BITS = 24;
  localparam int RES_CAP     = 16;

  localparam int IDX_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_BITS = $clog2(NUM_SLOTS + 1);
  localparam int RES_BITS = $clog2(RES_CAP + 1);

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 24;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] remaining;
    logic [PERIOD_BITS-1:0] reload;
    logic                   mode;
  } slot_entry_t;

  typedef struct packed {
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    slot_entry_t         wr_data;
  } ram_req_t;

  // Clamp a start period to what a slot counter can hold.
  function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [PERIOD_W-1:0] p);
    logic [47:0] wide;
    logic [47:0] pmask;
    wide  = 48'(p);
    pmask = (48'd1 << PERIOD_BITS) - 48'd1;
    if (wide > pmask) begin
      wide = pmask;
    end
    return wide[PERIOD_BITS-1:0];
  endfunction

endpackage

/* rtl/multi_slot_tick_timer.sv */
// Top level of the multi-slot tick timer.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------------
//   command  | start, busy             | kind, slot, period_ticks, periodic
//   result   | done (one-cycle strobe) | status, expired, expired_slot, last
//
// Start and stop items leave busy low; their single result shows in the next cycle.
// A tick item scans every slot through the slot memory, one read per cycle, and
// holds busy through the scan and flush states; expiries come out in slot order during the scan
// and the final result appears in the same cycle that busy falls.
// Reset clears the armed flags and the sequencer; the slot memory is not cleared.
// Results are never stalled: each done pulse is taken in the cycle it shows.
module multi_slot_tick_timer
  import mstt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [PERIOD_W-1:0] period_ticks,
  input  logic                periodic,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                expired,
  output logic [SLOT_W-1:0]   expired_slot,
  output logic                last
);

  ram_req_t    ram_req;
  slot_entry_t ram_rdata;

  mstt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .slot         (slot),
    .period_ticks (period_ticks),
    .periodic     (periodic),
    .done         (done),
    .status       (status),
    .expired      (expired),
    .expired_slot (expired_slot),
    .last         (last),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata)
  );

  mstt_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/mstt_slot_ram.sv */
// Slot memory: one write port and one registered read port.
module mstt_slot_ram
  import mstt_pkg::*;
(
  input  logic        clk,
  input  ram_req_t    req,
  output slot_entry_t rdata
);

  slot_entry_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

/* rtl/mstt_ctrl.sv */
// Command decode, tick scan sequencer, armed flags and result register.
module mstt_ctrl
  import mstt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [SLOT_W-1:0]   slot,
  input  logic [PERIOD_W-1:0] period_ticks,
  input  logic                periodic,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                expired,
  output logic [SLOT_W-1:0]   expired_slot,
  output logic                last,
  output ram_req_t            ram_req,
  input  slot_entry_t         ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [NUM_SLOTS-1:0]   armed;
  logic [CNT_BITS-1:0]    rd_cnt;
  logic                   proc_valid;
  logic [IDX_BITS-1:0]    proc_idx;
  logic [RES_BITS-1:0]    res_cnt;
  logic                   have_pend;
  logic [IDX_BITS-1:0]    pend_idx;

  logic                   accept;
  logic                   slot_ok;
  logic [IDX_BITS-1:0]    sidx;
  logic                   rd_go;
  logic [PERIOD_BITS-1:0] dec;
  logic                   hit;
  logic                   report;
  logic [STATUS_W-1:0]    cmd_status;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign slot_ok = (32'(slot) < NUM_SLOTS);
  assign sidx    = IDX_BITS'(slot);
  assign rd_go   = (state == S_SCAN) && (32'(rd_cnt) < NUM_SLOTS);
  assign dec     = ram_rdata.remaining - 1'b1;
  assign hit     = (state == S_SCAN) && proc_valid && armed[proc_idx] && (dec == '0);
  assign report  = hit && (32'(res_cnt) < RES_CAP);

  always_comb begin
    cmd_status = ST_INVALID;
    case (kind)
      KIND_START: begin
        if (!slot_ok || period_ticks == '0) begin
          cmd_status = ST_INVALID;
        end else if (armed[sidx]) begin
          cmd_status = ST_BUSY;
        end else begin
          cmd_status = ST_OK;
        end
      end
      KIND_STOP: begin
        if (!slot_ok) begin
          cmd_status = ST_INVALID;
        end else if (!armed[sidx]) begin
          cmd_status = ST_BUSY;
        end else begin
          cmd_status = ST_OK;
        end
      end
      default: cmd_status = ST_INVALID;
    endcase
  end

  always_comb begin
    ram_req         = '0;
    ram_req.rd_en   = rd_go;
    ram_req.rd_addr = rd_cnt[IDX_BITS-1:0];
    if (accept && kind == KIND_START && cmd_status == ST_OK) begin
      ram_req.wr_en             = 1'b1;
      ram_req.wr_addr           = sidx;
      ram_req.wr_data.remaining = sat_period(period_ticks);
      ram_req.wr_data.reload    = sat_period(period_ticks);
      ram_req.wr_data.mode      = periodic;
    end else if ((state == S_SCAN) && proc_valid && armed[proc_idx]) begin
      // A periodic slot that hits zero takes its reload value in the same write.
      ram_req.wr_en             = 1'b1;
      ram_req.wr_addr           = proc_idx;
      ram_req.wr_data           = ram_rdata;
      ram_req.wr_data.remaining = (dec == '0) ? ram_rdata.reload : dec;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && kind == KIND_TICK) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!rd_go && proc_valid) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      armed      <= '0;
      rd_cnt     <= '0;
      proc_valid <= 1'b0;
      res_cnt    <= '0;
      have_pend  <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      done       <= 1'b0;
      proc_valid <= rd_go;
      if (rd_go) begin
        rd_cnt <= rd_cnt + 1'b1;
      end

      if (accept) begin
        rd_cnt    <= '0;
        res_cnt   <= '0;
        have_pend <= 1'b0;
        if (kind != KIND_TICK) begin
          done <= 1'b1;
          if (kind == KIND_START && cmd_status == ST_OK) begin
            armed[sidx] <= 1'b1;
          end
          if (kind == KIND_STOP && cmd_status == ST_OK) begin
            armed[sidx] <= 1'b0;
          end
        end
      end

      if (hit && !ram_rdata.mode) begin
        armed[proc_idx] <= 1'b0;
      end

      // An expiry is held back one step so the final one can carry last.
      if (report) begin
        res_cnt   <= res_cnt + 1'b1;
        have_pend <= 1'b1;
        if (have_pend) begin
          done <= 1'b1;
        end
      end

      if (state == S_FLUSH) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    // The slot read this cycle is processed next cycle, when its data returns.
    if (rd_go) begin
      proc_idx <= rd_cnt[IDX_BITS-1:0];
    end
    if (report) begin
      pend_idx <= proc_idx;
    end
    if (accept) begin
      status       <= cmd_status;
      expired      <= 1'b0;
      expired_slot <= '0;
      last         <= 1'b1;
    end else if (report) begin
      status       <= ST_OK;
      expired      <= 1'b1;
      expired_slot <= SLOT_W'(pend_idx);
      last         <= 1'b0;
    end else if (state == S_FLUSH) begin
      status       <= ST_OK;
      expired      <= have_pend;
      expired_slot <= have_pend ? SLOT_W'(pend_idx) : '0;
      last         <= 1'b1;
    end
  end

endmodule

/* rtl/mstt_checker.sv */
// Port-level checker for the multi-slot tick timer, bound to the top level.
`include "multi_slot_tick_timer_assert.svh"

module mstt_checker
  import mstt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic [KIND_W-1:0]   kind,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic                expired,
  input logic                last
);

  logic acc_tick;
  logic acc_cmd;

  assign acc_tick = start && !busy && (kind == KIND_TICK);
  assign acc_cmd  = start && !busy && (kind != KIND_TICK);

  // A start, stop or unused item answers with exactly one plain result next cycle.
  `MSTT_ASSERT_NEXT(a_cmd_result, clk, rst, acc_cmd, done && last && !expired, "command item result missing")
  // A tick item holds the block busy while the slots are scanned.
  `MSTT_ASSERT_NEXT(a_tick_busy, clk, rst, acc_tick, busy && !done, "tick item did not start a scan")
  // Expiry results always report success.
  `MSTT_ASSERT_NOW(a_expiry_ok, clk, rst, done && expired, status == ST_OK, "expiry with bad status")
  // A result without an expiry is always the only one for its item.
  `MSTT_ASSERT_NOW(a_plain_last, clk, rst, done && !expired, last, "plain result without last")

endmodule

bind multi_slot_tick_timer mstt_checker u_mstt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .kind   (kind),
  .done   (done),
  .status (status),
  .expired(expired),
  .last   (last)
);
